### design/lfr_pkg.sv
// ---------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the literal find-and-replace stream block.
// ---------------------------------------------------------------------------
package lfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
    localparam int REP_IDX_W   = $clog2(REPLACE_MAX);
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_OUTPUT_LIMIT       = 3'd4
    } t_cfg_reg;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             end_of_output;
        logic [CNT_W-1:0] total_length;
        logic             overflow;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_CLOSE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;      // load input word into window
        logic copy_front;  // emit oldest window byte, drop it
        logic emit_repl;   // emit next replacement byte
        logic drop_match;  // clear window after a full match
        logic close;       // emit closing word, clear stream state
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word
        logic empty;       // window holds no byte
        logic one_left;    // window holds exactly one byte
        logic prefix_ok;   // window agrees with the pattern so far
        logic full_match;  // window holds the complete pattern
        logic last;        // current word ended the stream
        logic repl_empty;  // replacement length is zero
        logic repl_done;   // current replacement byte is the final one
    } t_dp_status;

endpackage

### design/literal_find_replace_stream.sv
// A source byte goes into the window, then a scan copies it to the output register.
// Each word is accepted in ST_IDLE and scanned in ST_SCAN before the next is taken;
//   a completed match emits the replacement bytes in ST_REPL, bytes flushed on a
//   rescan go out from ST_SCAN, and a stream end adds the closing word in ST_CLOSE.
// The single output register stalls the scan under backpressure.
// Reset: synchronous, active low; clears the window count, stream state and config.
// ---------------------------------------------------------------------------
// literal_find_replace_stream
// Copies a byte stream, replacing each non-overlapping pattern occurrence
// with a replacement string; closes each stream with a status word.
// ---------------------------------------------------------------------------
module literal_find_replace_stream (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfr_pkg::t_in_item    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfr_pkg::t_out_item   o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  lfr_pkg::t_cfg_idx    i_cfg_index,
    input  lfr_pkg::t_cfg_data   i_cfg_data
);
    import lfr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // accepting a word never overlaps an emit or a close
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.copy_front, cmd.emit_repl, cmd.close}))
        else $error("accept overlaps an emit");

    // a word is scanned before the next one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

    // close always shows the closing word next cycle
    a_close_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.close |=> (o_out_valid && o_out_word.end_of_output && !o_out_word.byte_valid))
        else $error("closing word missing");

    // replacement bytes are only emitted when a replacement exists
    a_repl_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_repl |-> !status.repl_empty)
        else $error("replacement emitted with zero length");

endmodule

### design/lfr_ctrl.sv
// ---------------------------------------------------------------------------
// lfr_ctrl
// Scan sequencer: accepts a word, then walks the match/copy/replace steps.
// ---------------------------------------------------------------------------
module lfr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lfr_pkg::t_dp_status   i_status,
    output lfr_pkg::t_dp_cmd      o_cmd
);
    import lfr_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state done_state;

    // where to go once the window has drained
    assign done_state = i_status.last ? ST_CLOSE : ST_IDLE;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.empty) begin
                    n_state = done_state;
                end else if (i_status.full_match) begin
                    n_state = i_status.repl_empty ? done_state : ST_REPL;
                end else if (i_status.prefix_ok && !i_status.last) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free && i_status.one_left) begin
                    n_state = done_state;
                end
            end
            ST_REPL: begin
                if (i_status.out_free && i_status.repl_done) begin
                    n_state = done_state;
                end
            end
            ST_CLOSE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCAN: begin
                if (!i_status.empty) begin
                    if (i_status.full_match) begin
                        o_cmd.drop_match = i_status.repl_empty;
                    end else if (!(i_status.prefix_ok && !i_status.last)) begin
                        o_cmd.copy_front = i_status.out_free;
                    end
                end
            end
            ST_REPL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_repl  = 1'b1;
                    o_cmd.drop_match = i_status.repl_done;
                end
            end
            ST_CLOSE: begin
                o_cmd.close = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### design/lfr_dp.sv
// ---------------------------------------------------------------------------
// lfr_dp
// Datapath: config registers, pending window, pattern compare, output limit
// tracking and the output register.
// ---------------------------------------------------------------------------
module lfr_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  lfr_pkg::t_cfg_idx     i_cfg_index,
    input  lfr_pkg::t_cfg_data    i_cfg_data,
    input  lfr_pkg::t_in_item     i_in_word,
    input  lfr_pkg::t_dp_cmd      i_cmd,
    output lfr_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lfr_pkg::t_out_item    o_out_word
);
    import lfr_pkg::*;

    // configuration
    logic [8*PATTERN_MAX-1:0] r_pat;
    logic [LEN_W-1:0]         r_pat_len;
    logic [8*REPLACE_MAX-1:0] r_rep;
    logic [LEN_W-1:0]         r_rep_len;
    logic [CNT_W-1:0]         r_limit;

    // stream state
    logic [7:0]               r_win [PATTERN_MAX];
    logic [LEN_W-1:0]         r_count;
    logic [LEN_W-1:0]         r_al;
    logic [REP_IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]         r_produced;
    logic                     r_ovf;
    logic                     r_last;

    // output register
    logic                     r_out_valid;
    t_out_item                r_out_word;

    logic [LEN_W-1:0]         pat_len_c;
    logic [LEN_W-1:0]         rep_len_c;
    logic [LEN_W-1:0]         cmp_len;
    logic                     prefix_ok;
    logic                     out_free;
    logic                     emit_req;
    logic [7:0]               emit_data;
    logic                     would_ovf;
    logic                     do_emit;

    // saturated lengths
    assign pat_len_c = (r_pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_pat_len;
    assign rep_len_c = (r_rep_len > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : r_rep_len;

    // compare held bytes against the pattern prefix
    assign cmp_len = (r_count < r_al) ? r_count : r_al;
    always_comb begin
        prefix_ok = (r_al != '0);
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((LEN_W'(j) < cmp_len) && (r_win[j] != r_pat[8*j +: 8])) begin
                prefix_ok = 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_status            = '0;
        o_status.out_free   = out_free;
        o_status.empty      = (r_count == '0);
        o_status.one_left   = (r_count == LEN_W'(1));
        o_status.prefix_ok  = prefix_ok;
        o_status.full_match = prefix_ok && (r_count >= r_al);
        o_status.last       = r_last;
        o_status.repl_empty = (rep_len_c == '0);
        o_status.repl_done  = ({1'b0, r_idx} + LEN_W'(1)) == rep_len_c;
    end

    // byte emission with output limit check
    assign emit_req  = i_cmd.copy_front || i_cmd.emit_repl;
    assign emit_data = i_cmd.copy_front ? r_win[0] : r_rep[8*r_idx +: 8];
    assign would_ovf = ({1'b0, r_produced} + (CNT_W+1)'(1)) >= {1'b0, r_limit};
    assign do_emit   = emit_req && !r_ovf && !would_ovf;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat     <= '0;
            r_pat_len <= '0;
            r_rep     <= '0;
            r_rep_len <= '0;
            r_limit   <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:      r_pat     <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_rep     <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rep_len <= i_cfg_data[LEN_W-1:0];
                CFG_OUTPUT_LIMIT:       r_limit   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pending window contents (no reset, read only below the count)
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_win[r_count[WIN_IDX_W-1:0]] <= i_in_word.in_byte;
        end else if (i_cmd.copy_front) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    // stream control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_al       <= '0;
            r_idx      <= '0;
            r_produced <= '0;
            r_ovf      <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_in_word.last_byte;
                if (r_count == '0) begin
                    r_al <= pat_len_c;
                end
                if (r_count < LEN_W'(PATTERN_MAX)) begin
                    r_count <= r_count + LEN_W'(1);
                end
            end
            if (i_cmd.copy_front) begin
                r_count <= r_count - LEN_W'(1);
            end
            // a full match with no replacement, or the final replacement byte, clears the window
            if (i_cmd.drop_match) begin
                r_count <= '0;
                r_idx   <= '0;
            end else if (i_cmd.emit_repl) begin
                r_idx <= r_idx + REP_IDX_W'(1);
            end
            // limit tracking
            if (emit_req && !r_ovf) begin
                if (would_ovf) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_produced <= r_produced + CNT_W'(1);
                end
            end
            if (i_cmd.close) begin
                r_count    <= '0;
                r_idx      <= '0;
                r_produced <= '0;
                r_ovf      <= 1'b0;
                r_last     <= 1'b0;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit || i_cmd.close) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_word.out_byte      <= emit_data;
            r_out_word.byte_valid    <= 1'b1;
            r_out_word.end_of_output <= 1'b0;
            r_out_word.total_length  <= '0;
            r_out_word.overflow      <= 1'b0;
        end else if (i_cmd.close) begin
            r_out_word.out_byte      <= '0;
            r_out_word.byte_valid    <= 1'b0;
            r_out_word.end_of_output <= 1'b1;
            r_out_word.total_length  <= r_ovf ? '0 : r_produced;
            r_out_word.overflow      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
